// ===== design/hsvsa_pkg.sv =====
// Shared types and codes for the HSV shade adjuster.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package hsvsa_pkg;

  localparam int PIX_W = 8;
  localparam int ACT_W = 3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ACT_W-1:0] act_t;

  // shade actions; the unused codes fall through as no change
  localparam act_t ACT_NONE     = 3'd0;
  localparam act_t ACT_LIGHTER  = 3'd1;
  localparam act_t ACT_LIGHTEST = 3'd2;
  localparam act_t ACT_DARKER   = 3'd3;
  localparam act_t ACT_DARKEST  = 3'd4;

endpackage

`default_nettype wire

// ===== design/hsvsa_if.sv =====
// Valid/ready channel interfaces for source and adjusted pixels.
// Depends on hsvsa_pkg.
`default_nettype none

interface hsvsa_in_if;
  import hsvsa_pkg::*;
  logic valid;
  logic ready;
  pix_t red_in;
  pix_t green_in;
  pix_t blue_in;
  act_t action;
  modport source (output valid, red_in, green_in, blue_in, action, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, action, output ready);
endinterface

interface hsvsa_out_if;
  import hsvsa_pkg::*;
  logic valid;
  logic ready;
  pix_t red_out;
  pix_t green_out;
  pix_t blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

// ===== design/hsv_color_shade_adjust_top.sv =====
// HSV shade adjuster: RGB -> HSV (fixed point), value/hue adjust, HSV -> RGB.
// Depends on hsvsa_pkg and the channel interfaces in hsvsa_if.sv.
//
// Usage:
//   pix_in carries one source pixel (red_in, green_in, blue_in) and an action
//   per beat; pix_out carries the adjusted pixel. Exactly one output beat is
//   produced for each input beat, in order.
//   Throughput: one beat per clock while pix_out is not stalled. Every stage
//   is a register slice and the two long divisions (hue ratio and saturation)
//   are unrolled into one quotient bit per stage, so a new pixel can enter
//   every cycle unless a waiting output beat holds the pipe.
//   Pipeline: two front stages, FRAC_BITS + 1 divider stages and nine stages
//   of hue/value math, back conversion and byte rounding.
//   Stall: the whole pipe holds while the output beat waits; pix_in.ready is
//   high whenever the last stage is empty or is being taken, so nothing is
//   dropped or repeated, and a waiting result holds off new input until taken.
//   Reset (rst, synchronous, active high) empties the pipe; there is no
//   other state and no configuration.
`default_nettype none

module hsv_color_shade_adjust_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire       clk,
  input  wire       rst,
  hsvsa_in_if.sink    pix_in,
  hsvsa_out_if.source pix_out
);
  import hsvsa_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int FW  = F + 1;        // unsigned fixed value in [0, ONE]
  localparam int HW  = F + 11;       // signed hue in degrees
  localparam int HQW = F + 7;        // hue / 4 magnitude
  localparam int K3  = F + 3;
  localparam int M3W = F + 2;
  localparam int K15 = F + 11;
  localparam int M15W = F + 8;
  localparam int HSW = F + 3;        // hue / 60

  localparam logic [FW-1:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [63:0]   M3L  = ((64'd1 << K3) + 64'd2) / 64'd3;
  localparam logic [63:0]   M15L = ((64'd1 << K15) + 64'd14) / 64'd15;
  localparam logic [M3W-1:0]  M3  = M3L[M3W-1:0];
  localparam logic [M15W-1:0] M15 = M15L[M15W-1:0];
  localparam logic signed [HW-1:0] H360 = HW'(360) << F;
  localparam logic signed [HW-1:0] HHALF = HW'(1) << (F - 1);

  logic adv;
  logic i_vld;
  assign adv = !i_vld || pix_out.ready;
  assign pix_in.ready = adv;

  // byte to fixed: c * 2^24 / 255 = c * 65793 + (c == 255), then rescale
  function automatic logic [FW-1:0] to_fix(input pix_t c);
    logic [24:0] t;
    t = {17'd0, c} * 25'd65793 + {24'd0, (c == 8'd255)};
    return FW'(t >> (24 - F));
  endfunction

  // ---------------- stage 0: scale to fixed
  logic          s0_vld;
  logic [FW-1:0] s0_r, s0_g, s0_b;
  act_t          s0_act;

  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else if (adv) s0_vld <= pix_in.valid;
    if (adv) begin
      s0_r   <= to_fix(pix_in.red_in);
      s0_g   <= to_fix(pix_in.green_in);
      s0_b   <= to_fix(pix_in.blue_in);
      s0_act <= pix_in.action;
    end
  end

  // ---------------- stage 1: max/min, hue numerator, divider setup
  typedef struct packed {
    logic          vld;
    logic [FW-1:0] v;
    logic [FW-1:0] dh;
    logic [FW-1:0] ds;
    logic [FW:0]   rh;
    logic [FW:0]   rs;
    logic [FW-1:0] qh;
    logic [FW-1:0] qs;
    logic          neg;
    logic [2:0]    off;
    logic          sz;
    act_t          act;
  } dv_t;

  dv_t dv [0:F+1];
  dv_t dv_nxt [0:F];
  dv_t s1_nxt;

  always_comb begin
    logic [FW-1:0] mx, mn;
    logic signed [FW:0] num;
    mx = (s0_r > s0_g) ? s0_r : s0_g;
    if (s0_b > mx) mx = s0_b;
    mn = (s0_r < s0_g) ? s0_r : s0_g;
    if (s0_b < mn) mn = s0_b;
    if (s0_r == mx) begin
      num = $signed({1'b0, s0_g}) - $signed({1'b0, s0_b});
      s1_nxt.off = 3'd0;
    end else if (s0_g == mx) begin
      num = $signed({1'b0, s0_b}) - $signed({1'b0, s0_r});
      s1_nxt.off = 3'd2;
    end else begin
      num = $signed({1'b0, s0_r}) - $signed({1'b0, s0_g});
      s1_nxt.off = 3'd4;
    end
    s1_nxt.vld = s0_vld;
    s1_nxt.v   = mx;
    s1_nxt.dh  = mx - mn;
    s1_nxt.ds  = mx;
    s1_nxt.neg = num[FW];
    s1_nxt.rh  = num[FW] ? (FW+1)'(-num) : {1'b0, num[FW-1:0]};
    s1_nxt.rs  = {1'b0, mx - mn};
    s1_nxt.qh  = '0;
    s1_nxt.qs  = '0;
    s1_nxt.sz  = (mx == mn);
    s1_nxt.act = s0_act;
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0].vld <= 1'b0;
    else if (adv) dv[0] <= s1_nxt;
  end

  // ---------------- divider: one quotient bit of each division per stage
  for (genvar k = 0; k <= F; k++) begin : g_div
    always_comb begin
      logic [FW:0] rh_sh, rs_sh;
      logic        bh, bs;
      dv_nxt[k] = dv[k];
      rh_sh = (k == 0) ? dv[k].rh : {dv[k].rh[FW-1:0], 1'b0};
      rs_sh = (k == 0) ? dv[k].rs : {dv[k].rs[FW-1:0], 1'b0};
      bh = (rh_sh >= {1'b0, dv[k].dh});
      bs = (rs_sh >= {1'b0, dv[k].ds});
      dv_nxt[k].rh = bh ? rh_sh - {1'b0, dv[k].dh} : rh_sh;
      dv_nxt[k].rs = bs ? rs_sh - {1'b0, dv[k].ds} : rs_sh;
      dv_nxt[k].qh = {dv[k].qh[FW-2:0], bh};
      dv_nxt[k].qs = {dv[k].qs[FW-2:0], bs};
    end

    always_ff @(posedge clk) begin
      if (rst) dv[k+1].vld <= 1'b0;
      else if (adv) dv[k+1] <= dv_nxt[k];
    end
  end

  // ---------------- stage A: signed hue ratio plus sector, v * (1/3)
  logic                     a_vld;
  logic signed [HW-1:0]     a_hb;
  logic [FW+M3W-1:0]        a_v3p;
  logic [FW-1:0]            a_v, a_s;
  logic                     a_sz;
  act_t                     a_act;

  always_ff @(posedge clk) begin
    logic signed [HW-1:0] hq;
    hq = $signed({{(HW-FW){1'b0}}, dv[F+1].qh});
    if (rst) a_vld <= 1'b0;
    else if (adv) a_vld <= dv[F+1].vld;
    if (adv) begin
      a_hb  <= $signed(HW'(dv[F+1].off) << F) + (dv[F+1].neg ? -hq : hq);
      a_v3p <= dv[F+1].v * M3;
      a_v   <= dv[F+1].v;
      a_s   <= dv[F+1].qs;
      a_sz  <= dv[F+1].sz;
      a_act <= dv[F+1].act;
    end
  end

  // ---------------- stage B: hue in degrees, v/3 (v/6 is taken in stage C)
  logic                 b_vld;
  logic signed [HW-1:0] b_h;
  logic [FW-1:0]        b_v3, b_v, b_s;
  logic                 b_sz;
  act_t                 b_act;

  always_ff @(posedge clk) begin
    logic signed [HW-1:0] h60;
    h60 = (a_hb <<< 6) - (a_hb <<< 2);
    if (rst) b_vld <= 1'b0;
    else if (adv) b_vld <= a_vld;
    if (adv) begin
      b_h   <= (h60 < 0) ? h60 + H360 : h60;
      b_v3  <= FW'(a_v3p >> K3);
      b_v   <= a_v;
      b_s   <= a_s;
      b_sz  <= a_sz;
      b_act <= a_act;
    end
  end

  // ---------------- stage C: value adjust, rounded hue for the pull
  logic                 c_vld;
  logic signed [HW-1:0] c_h;
  logic [8:0]           c_hi;
  logic                 c_pull, c_half;
  logic [FW-1:0]        c_v, c_s;
  logic                 c_sz;

  always_ff @(posedge clk) begin
    logic [FW-1:0] v6, inc, vn;
    logic [FW:0]   vsum;
    logic          pull, half;
    logic signed [HW-1:0] hsum;
    v6   = b_v3 >> 1;
    vn   = b_v;
    pull = 1'b0;
    half = 1'b0;
    vsum = '0;
    inc  = '0;
    unique case (b_act)
      ACT_DARKER:  vn = b_v - v6;
      ACT_DARKEST: vn = b_v - b_v3;
      ACT_LIGHTER, ACT_LIGHTEST: begin
        half = (b_act == ACT_LIGHTER);
        if (b_v < ONE) begin
          inc  = half ? v6 : b_v3;
          vsum = {1'b0, b_v} + {1'b0, inc};
          vn   = (vsum >= {1'b0, ONE}) ? ONE : vsum[FW-1:0];
        end else begin
          vn   = ONE;
          pull = 1'b1;
        end
      end
      default: vn = b_v;
    endcase
    hsum = b_h + HHALF;
    if (rst) c_vld <= 1'b0;
    else if (adv) c_vld <= b_vld;
    if (adv) begin
      c_h    <= b_h;
      c_hi   <= 9'(hsum >>> F);
      c_pull <= pull;
      c_half <= half;
      c_v    <= vn;
      c_s    <= b_s;
      c_sz   <= b_sz;
    end
  end

  // ---------------- stage D: pull hue toward 60/180/300
  logic                 d_vld;
  logic signed [HW-1:0] d_h;
  logic [FW-1:0]        d_v, d_s;
  logic                 d_sz;

  always_ff @(posedge clk) begin
    logic              on60;
    logic [1:0]        q120;
    logic [9:0]        aim;
    logic signed [10:0] dd, dsh, nh;
    on60 = (c_hi == 9'd0) || (c_hi == 9'd60) || (c_hi == 9'd120) ||
           (c_hi == 9'd180) || (c_hi == 9'd240) || (c_hi == 9'd300) ||
           (c_hi == 9'd360);
    q120 = 2'((c_hi >= 9'd120) ? 1 : 0) + 2'((c_hi >= 9'd240) ? 1 : 0) +
           2'((c_hi >= 9'd360) ? 1 : 0);
    aim  = 10'(q120) * 10'd120 + 10'd60;
    dd   = $signed({1'b0, aim}) - $signed({2'b0, c_hi});
    dsh  = c_half ? (dd >>> 1) : (dd >>> 2);
    nh   = $signed({1'b0, aim}) - dsh;
    if (rst) d_vld <= 1'b0;
    else if (adv) d_vld <= c_vld;
    if (adv) begin
      d_h  <= (c_pull && !on60) ? (HW'(nh) <<< F) : c_h;
      d_v  <= c_v;
      d_s  <= c_s;
      d_sz <= c_sz;
    end
  end

  // ---------------- stage E: hue / 60 by reciprocal of 15 on hue / 4
  logic                  e_vld;
  logic [HQW+M15W-1:0]   e_hp;
  logic [FW-1:0]         e_v, e_s;
  logic                  e_sz;

  always_ff @(posedge clk) begin
    logic [HW-1:0] hu;
    hu = d_h;
    if (rst) e_vld <= 1'b0;
    else if (adv) e_vld <= d_vld;
    if (adv) begin
      e_hp <= hu[HQW+1:2] * M15;
      e_v  <= d_v;
      e_s  <= d_s;
      e_sz <= d_sz;
    end
  end

  // ---------------- stage F: sector, fraction, first products
  logic                 f_vld;
  logic [2:0]           f_sec;
  logic [FW+F-1:0]      f_sf;
  logic [2*FW-1:0]      f_sf1, f_pp;
  logic [FW-1:0]        f_v;
  logic                 f_sz;

  always_ff @(posedge clk) begin
    logic [HSW-1:0] hs;
    logic [2:0]     hr;
    logic [F-1:0]   fr;
    logic [2:0]     sec;
    hs = e_hp[K15 +: HSW];
    hr = hs[HSW-1:F];
    fr = hs[F-1:0];
    case (hr)
      3'd6:    sec = 3'd0;
      3'd7:    sec = 3'd1;
      default: sec = hr;
    endcase
    if (rst) f_vld <= 1'b0;
    else if (adv) f_vld <= e_vld;
    if (adv) begin
      f_sec <= sec;
      f_sf  <= e_s * fr;
      f_sf1 <= e_s * (ONE - {1'b0, fr});
      f_pp  <= e_v * (ONE - e_s);
      f_v   <= e_v;
      f_sz  <= e_sz;
    end
  end

  // ---------------- stage G: q and t products, p
  logic            g_vld;
  logic [2*FW-1:0] g_qp, g_tp;
  logic [FW-1:0]   g_p, g_v;
  logic [2:0]      g_sec;
  logic            g_sz;

  always_ff @(posedge clk) begin
    logic [FW-1:0] sf, sf1;
    sf  = FW'(f_sf >> F);
    sf1 = FW'(f_sf1 >> F);
    if (rst) g_vld <= 1'b0;
    else if (adv) g_vld <= f_vld;
    if (adv) begin
      g_qp  <= f_v * (ONE - sf);
      g_tp  <= f_v * (ONE - sf1);
      g_p   <= FW'(f_pp >> F);
      g_v   <= f_v;
      g_sec <= f_sec;
      g_sz  <= f_sz;
    end
  end

  // ---------------- stage H: pick channels by sector
  logic          h_vld;
  logic [FW-1:0] h_r, h_g, h_b;

  always_ff @(posedge clk) begin
    logic [FW-1:0] q, t, ro, go, bo;
    q = FW'(g_qp >> F);
    t = FW'(g_tp >> F);
    case (g_sec)
      3'd0:    begin ro = g_v; go = t;   bo = g_p; end
      3'd1:    begin ro = q;   go = g_v; bo = g_p; end
      3'd2:    begin ro = g_p; go = g_v; bo = t;   end
      3'd3:    begin ro = g_p; go = q;   bo = g_v; end
      3'd4:    begin ro = t;   go = g_p; bo = g_v; end
      default: begin ro = g_v; go = g_p; bo = q;   end
    endcase
    if (g_sz) begin
      ro = g_v;
      go = g_v;
      bo = g_v;
    end
    if (rst) h_vld <= 1'b0;
    else if (adv) h_vld <= g_vld;
    if (adv) begin
      h_r <= ro;
      h_g <= go;
      h_b <= bo;
    end
  end

  // ---------------- stage I: round x * 255 to bytes (output register)
  function automatic pix_t to_byte(input logic [FW-1:0] x);
    logic [FW+8:0] k;
    logic [FW+8:0] kk;
    k  = ({1'b0, x, 8'd0} - {9'd0, x}) + ((FW+9)'(1) << (F - 1));
    kk = k >> F;
    return (kk > (FW+9)'(255)) ? 8'hFF : kk[7:0];
  endfunction

  pix_t i_r, i_g, i_b;

  always_ff @(posedge clk) begin
    if (rst) i_vld <= 1'b0;
    else if (adv) i_vld <= h_vld;
    if (adv) begin
      i_r <= to_byte(h_r);
      i_g <= to_byte(h_g);
      i_b <= to_byte(h_b);
    end
  end

  assign pix_out.valid     = i_vld;
  assign pix_out.red_out   = i_r;
  assign pix_out.green_out = i_g;
  assign pix_out.blue_out  = i_b;

endmodule

`default_nettype wire

// ===== tb/hsv_color_shade_adjust_top_tb.sv =====
// Testbench for the HSV shade adjuster: directed pixels, then random, back-pressure and full-rate traffic.
// Depends on hsvsa_pkg, hsvsa_if.sv and hsv_color_shade_adjust_top.
`default_nettype none

module hsv_color_shade_adjust_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsvsa_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint HALF = ONE / 2;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  hsvsa_in_if pix_in ();
  hsvsa_out_if pix_out ();

  hsv_color_shade_adjust_top #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rgb_t shade_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit no_stall = 1'b0;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic pix_t fix_to_byte(longint x);
    longint k;
    k = fdiv(x * 255 + HALF, ONE);
    if (k < 0) k = 0;
    if (k > 255) k = 255;
    return pix_t'(k);
  endfunction

  function automatic rgb_t predict_shade(pix_t ri, pix_t gi, pix_t bi, act_t act);
    longint r, g, b, mx, mn, delta, h, s, v, hs, hr, f, p, q, t, ro, go, bo;
    longint inc, hi, aim, d;
    int sector;
    rgb_t res;
    r = longint'(ri) * ONE / 255;
    g = longint'(gi) * ONE / 255;
    b = longint'(bi) * ONE / 255;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    v = mx;
    delta = mx - mn;
    if (mx == 0) begin
      s = 0; h = -ONE;
    end else if (delta == 0) begin
      s = 0; h = 0;
    end else begin
      s = delta * ONE / mx;
      if (r == mx) h = (g - b) * ONE / delta;
      else if (g == mx) h = 2 * ONE + (b - r) * ONE / delta;
      else h = 4 * ONE + (r - g) * ONE / delta;
      h = h * 60;
      if (h < 0) h += 360 * ONE;
    end
    if (act == ACT_DARKER) begin
      v -= v / 6;
    end else if (act == ACT_DARKEST) begin
      v -= v / 3;
    end else if (act == ACT_LIGHTER || act == ACT_LIGHTEST) begin
      if (v < ONE) begin
        inc = v / 3;
        if (act == ACT_LIGHTER) inc >>= 1;
        v += inc;
        if (v >= ONE) v = ONE;
      end else begin
        hi = fdiv(h + HALF, ONE);
        v = ONE;
        if (hi % 60 != 0) begin
          aim = fdiv(hi, 120) * 120 + 60;
          d = fdiv(aim - hi, 2);
          if (act == ACT_LIGHTEST) d = fdiv(d, 2);
          h = (aim - d) * ONE;
        end
      end
    end
    if (s == 0) begin
      ro = v; go = v; bo = v;
    end else begin
      if (h < 0) h = 0;
      hs = h / 60;
      hr = hs / ONE;
      sector = int'(hr % 6);
      f = hs - hr * ONE;
      p = v * (ONE - s) / ONE;
      q = v * (ONE - s * f / ONE) / ONE;
      t = v * (ONE - s * (ONE - f) / ONE) / ONE;
      case (sector)
        0: begin ro = v; go = t; bo = p; end
        1: begin ro = q; go = v; bo = p; end
        2: begin ro = p; go = v; bo = t; end
        3: begin ro = p; go = q; bo = v; end
        4: begin ro = t; go = p; bo = v; end
        default: begin ro = v; go = p; bo = q; end
      endcase
    end
    res.r = fix_to_byte(ro);
    res.g = fix_to_byte(go);
    res.b = fix_to_byte(bo);
    return res;
  endfunction

  initial begin
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.action = ACT_NONE;
    pix_out.ready = 1'b0;
  end

  // receiver: pattern of stalls, plus a long hold-off or no stalls on request
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst || hold_off) pix_out.ready <= 1'b0;
    else if (no_stall) pix_out.ready <= 1'b1;
    else pix_out.ready <= ((cycles % 11) < 7) ? ($urandom_range(0, 9) != 0)
                                              : ($urandom_range(0, 2) == 0);
  end

  // checker for each output beat
  always @(posedge clk) begin
    rgb_t exp_px;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (shade_q.size() == 0) begin
        $error("output beat with no expected pixel");
        errors++;
      end else begin
        exp_px = shade_q.pop_front();
        n_checked++;
        if (pix_out.red_out !== exp_px.r) begin
          $error("red_out expected %0d actual %0d", exp_px.r, pix_out.red_out);
          errors++;
        end
        if (pix_out.green_out !== exp_px.g) begin
          $error("green_out expected %0d actual %0d", exp_px.g, pix_out.green_out);
          errors++;
        end
        if (pix_out.blue_out !== exp_px.b) begin
          $error("blue_out expected %0d actual %0d", exp_px.b, pix_out.blue_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // offer one beat and hold it until accepted
  task automatic send_pixel(pix_t r, pix_t g, pix_t b, act_t act);
    pix_in.valid <= 1'b1;
    pix_in.red_in <= r;
    pix_in.green_in <= g;
    pix_in.blue_in <= b;
    pix_in.action <= act;
    do @(posedge clk); while (!pix_in.ready);
    shade_q.push_back(predict_shade(r, g, b, act));
    n_sent++;
  endtask

  task automatic idle_cycles(int n);
    pix_in.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (shade_q.size() != 0) @(posedge clk);
  endtask

  function automatic act_t rand_action();
    return act_t'($urandom_range(0, 99) < 90 ? $urandom_range(0, 4) : $urandom_range(5, 7));
  endfunction

  task automatic test_directed();
    act_t a;
    for (int i = 0; i < 5; i++) begin
      a = act_t'(i);
      send_pixel(8'd0, 8'd0, 8'd0, a);          // black
      send_pixel(8'd128, 8'd128, 8'd128, a);    // grey
      send_pixel(8'd255, 8'd40, 8'd0, a);       // full value, off-center hue
    end
    send_pixel(8'd255, 8'd255, 8'd255, ACT_LIGHTEST);
    send_pixel(8'd255, 8'd0, 8'd255, ACT_LIGHTER);
    send_pixel(8'd0, 8'd255, 8'd0, ACT_LIGHTEST);
    send_pixel(8'd0, 8'd0, 8'd255, ACT_DARKEST);
    send_pixel(8'd255, 8'd0, 8'd1, ACT_LIGHTER);  // hue just below 360
    send_pixel(8'd10, 8'd200, 8'd90, 3'd5);
    send_pixel(8'd200, 8'd10, 8'd90, 3'd7);
    drain_results();
  endtask

  task automatic test_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        case ($urandom_range(0, 5))
          0: send_pixel(pix_t'($urandom_range(0, 255)), pix_t'($urandom_range(0, 255)),
                        8'd255, rand_action());
          1: send_pixel(8'd255, pix_t'($urandom_range(0, 255)),
                        pix_t'($urandom_range(0, 255)), rand_action());
          default: send_pixel(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom),
                              rand_action());
        endcase
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  // receiver holds off long enough for the pipe to fill and stall input
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 60; i++)
        send_pixel(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom), rand_action());
    join
    drain_results();
  endtask

  task automatic test_full_rate();
    no_stall = 1'b1;
    for (int i = 0; i < 150; i++)
      send_pixel(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom), rand_action());
    drain_results();
    no_stall = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    drain_results();
    test_backpressure();
    test_full_rate();
    test_random(500);
    drain_results();
    idle_cycles(FB + 20);
    $display("Sent %0d pixels over all five actions and unused codes; %0d checked.",
             n_sent, n_checked);
    if (errors == 0 && shade_q.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
